### rtl/blcs_pkg.sv
// ----------------------------------------------------------------------------
// blcs_pkg
// Shared types, widths and register indexes for the best lepton cut selector.
// ----------------------------------------------------------------------------
`default_nettype none

package blcs_pkg;

    // object positions within one event
    localparam int MAX_OBJECTS = 64;
    localparam int CNT_W       = $clog2(MAX_OBJECTS);
    localparam int IDX_W       = 6;
    localparam int IDX_EXT_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // field widths
    localparam int MOM_W     = 16;
    localparam int ETA_W     = 12;
    localparam int ISO_W     = 16;
    localparam int IMP_W     = 16;
    localparam int ETA_CFG_W = 11;
    localparam int IMP_CFG_W = 15;
    localparam int ISO_SUM_W = ISO_W + 2;
    localparam int ISO_LHS_W = ISO_SUM_W + 8;
    localparam int ISO_RHS_W = ISO_W + MOM_W;

    // stream widths
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // queue between classifier and tracker
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOMENTUM_MIN     = 3'd0,
        REG_ABS_ETA_MAX      = 3'd1,
        REG_CRACK_LOW        = 3'd2,
        REG_CRACK_HIGH       = 3'd3,
        REG_ISOLATION_MAX    = 3'd4,
        REG_TRANS_IMPACT_MAX = 3'd5,
        REG_LONG_IMPACT_MAX  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [MOM_W-1:0]     momentum_min;
        logic [ETA_CFG_W-1:0] abs_eta_max;
        logic [ETA_CFG_W-1:0] crack_low;
        logic [ETA_CFG_W-1:0] crack_high;
        logic [ISO_W-1:0]     isolation_max;
        logic [IMP_CFG_W-1:0] transverse_impact_max;
        logic [IMP_CFG_W-1:0] longitudinal_impact_max;
    } t_cfg;

    // one classified object
    typedef struct packed {
        logic             pass;
        logic [MOM_W-1:0] momentum;
        logic             last;
    } t_cls;

endpackage

`default_nettype wire

### rtl/blcs_cfg.sv
// ----------------------------------------------------------------------------
// blcs_cfg
// Cut register file, written through a plain index/data write port.
// ----------------------------------------------------------------------------
`default_nettype none

module blcs_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [blcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [blcs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output blcs_pkg::t_cfg                        o_cfg
);
    import blcs_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.momentum_min            <= '0;
            r_cfg.abs_eta_max             <= '1;
            r_cfg.crack_low               <= '0;
            r_cfg.crack_high              <= '0;
            r_cfg.isolation_max           <= '1;
            r_cfg.transverse_impact_max   <= '1;
            r_cfg.longitudinal_impact_max <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MOMENTUM_MIN:     r_cfg.momentum_min <= i_cfg_data[MOM_W-1:0];
                REG_ABS_ETA_MAX:      r_cfg.abs_eta_max <= i_cfg_data[ETA_CFG_W-1:0];
                REG_CRACK_LOW:        r_cfg.crack_low <= i_cfg_data[ETA_CFG_W-1:0];
                REG_CRACK_HIGH:       r_cfg.crack_high <= i_cfg_data[ETA_CFG_W-1:0];
                REG_ISOLATION_MAX:    r_cfg.isolation_max <= i_cfg_data[ISO_W-1:0];
                REG_TRANS_IMPACT_MAX: begin
                    r_cfg.transverse_impact_max <= i_cfg_data[IMP_CFG_W-1:0];
                end
                REG_LONG_IMPACT_MAX:  begin
                    r_cfg.longitudinal_impact_max <= i_cfg_data[IMP_CFG_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/blcs_front.sv
// ----------------------------------------------------------------------------
// blcs_front
// Classifier: unpacks one object and applies all cuts in the request cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module blcs_front (
    input  blcs_pkg::t_cfg                        i_cfg,
    input  wire logic [blcs_pkg::IN_DATA_W-1:0]   i_data,
    input  wire logic                             i_last,
    output blcs_pkg::t_cls                        o_cls
);
    import blcs_pkg::*;

    logic [MOM_W-1:0]     momentum;
    logic [ETA_W-1:0]     eta;
    logic [ISO_W-1:0]     iso_trk;
    logic [ISO_W-1:0]     iso_em;
    logic [ISO_W-1:0]     iso_had;
    logic [IMP_W-1:0]     d0;
    logic [IMP_W-1:0]     dz;
    logic [ETA_W-1:0]     abs_eta;
    logic [IMP_W-1:0]     abs_d0;
    logic [IMP_W-1:0]     abs_dz;
    logic [ISO_SUM_W-1:0] iso_sum;
    logic [ISO_LHS_W-1:0] iso_lhs;
    logic [ISO_RHS_W-1:0] iso_rhs;
    logic                 fail_mom;
    logic                 fail_eta;
    logic                 fail_crack;
    logic                 fail_iso;
    logic                 fail_imp;

    // field unpacking, lowest field first
    assign momentum = i_data[15:0];
    assign eta      = i_data[27:16];
    assign iso_trk  = i_data[43:28];
    assign iso_em   = i_data[59:44];
    assign iso_had  = i_data[75:60];
    assign d0       = i_data[91:76];
    assign dz       = i_data[107:92];

    // magnitudes; most negative code maps to its unsigned magnitude
    assign abs_eta = eta[ETA_W-1] ? (~eta + 1'b1) : eta;
    assign abs_d0  = d0[IMP_W-1] ? (~d0 + 1'b1) : d0;
    assign abs_dz  = dz[IMP_W-1] ? (~dz + 1'b1) : dz;

    // relative isolation without division: sum*256 > iso_max*pt
    assign iso_sum = ISO_SUM_W'(iso_trk) + ISO_SUM_W'(iso_em) + ISO_SUM_W'(iso_had);
    assign iso_lhs = {iso_sum, 8'h00};
    assign iso_rhs = ISO_RHS_W'(i_cfg.isolation_max) * ISO_RHS_W'(momentum);

    // cuts
    assign fail_mom   = momentum < i_cfg.momentum_min;
    assign fail_eta   = abs_eta > ETA_W'(i_cfg.abs_eta_max);
    assign fail_crack = (abs_eta > ETA_W'(i_cfg.crack_low)) &&
                        (abs_eta < ETA_W'(i_cfg.crack_high));
    assign fail_iso   = (momentum != '0) && (ISO_RHS_W'(iso_lhs) > iso_rhs);
    assign fail_imp   = (abs_d0 > IMP_W'(i_cfg.transverse_impact_max)) ||
                        (abs_dz > IMP_W'(i_cfg.longitudinal_impact_max));

    assign o_cls.pass     = !(fail_mom || fail_eta || fail_crack || fail_iso || fail_imp);
    assign o_cls.momentum = momentum;
    assign o_cls.last     = i_last;

endmodule

`default_nettype wire

### rtl/blcs_fifo.sv
// ----------------------------------------------------------------------------
// blcs_fifo
// Short queue of classified objects between classifier and tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module blcs_fifo (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  blcs_pkg::t_cls i_wdata,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_empty,
    output blcs_pkg::t_cls o_rdata
);
    import blcs_pkg::*;

    t_cls               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = r_count == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_rdata = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/blcs_back.sv
// ----------------------------------------------------------------------------
// blcs_back
// Tracker: keeps the highest-momentum passing object and reports per event.
// ----------------------------------------------------------------------------
`default_nettype none

module blcs_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_empty,
    input  blcs_pkg::t_cls                         i_cls,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [blcs_pkg::OUT_DATA_W-1:0]        o_data
);
    import blcs_pkg::*;

    logic [CNT_W-1:0]     r_count;
    logic                 r_have;
    logic [CNT_W-1:0]     r_index;
    logic [MOM_W-1:0]     r_mom;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [IDX_W-1:0]     r_out_index;
    logic [MOM_W-1:0]     r_out_mom;

    logic                 out_free;
    logic                 take;
    logic                 n_have;
    logic [CNT_W-1:0]     n_index;
    logic [MOM_W-1:0]     n_mom;
    logic [IDX_EXT_W-1:0] index_ext;

    // a last object needs the output register free
    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = !i_empty && (!i_cls.last || out_free);

    // best candidate update
    assign take    = i_cls.pass && (!r_have || (i_cls.momentum > r_mom));
    assign n_have  = r_have || take;
    assign n_index = take ? r_count : r_index;
    assign n_mom   = take ? i_cls.momentum : r_mom;
    assign index_ext = IDX_EXT_W'(n_index);

    // event tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_have  <= 1'b0;
            r_index <= '0;
            r_mom   <= '0;
        end else if (o_pop) begin
            if (i_cls.last) begin
                r_count <= '0;
                r_have  <= 1'b0;
                r_index <= '0;
                r_mom   <= '0;
            end else begin
                if (r_count != CNT_W'(MAX_OBJECTS - 1)) begin
                    r_count <= r_count + 1'b1;
                end
                r_have  <= n_have;
                r_index <= n_index;
                r_mom   <= n_mom;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_cls.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last) begin
            r_out_found <= n_have;
            r_out_index <= n_have ? index_ext[IDX_W-1:0] : '0;
            r_out_mom   <= n_have ? n_mom : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {1'b0, r_out_mom, r_out_index, r_out_found};

endmodule

`default_nettype wire

### rtl/best_lepton_cut_selector.sv
// Throughput: one object per cycle while the queue is not full; the classifier
// does the cuts and the one 16x16 isolation multiply in the request cycle, the
// tracker retires one queued object per cycle unless a last object waits for a
// busy result register, and a 4-entry queue decouples the two.
// Reset: synchronous active low; clears queue, event state, result register
// and loads the default cut values.
// ----------------------------------------------------------------------------
// best_lepton_cut_selector
// Selects the highest-momentum lepton passing kinematic, isolation and impact
// cuts in each event and reports it at the event's last object.
// ----------------------------------------------------------------------------
`default_nettype none

module best_lepton_cut_selector (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [blcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [blcs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // object stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // momentum, pseudorapidity, track_isolation, calorimeter_em_isolation,
    // calorimeter_had_isolation, transverse_impact, longitudinal_impact
    input  wire logic [blcs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tlast,
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // found, best_index, best_momentum
    output logic [blcs_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import blcs_pkg::*;

    t_cfg cfg;
    t_cls cls_in;
    t_cls cls_out;
    logic fifo_full;
    logic fifo_empty;
    logic fifo_pop;
    logic push;

    assign s_axis_tready = !fifo_full;
    assign push          = s_axis_tvalid && !fifo_full;

    // cut registers
    blcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // classifier
    blcs_front u_front (
        .i_cfg  (cfg),
        .i_data (s_axis_tdata),
        .i_last (s_axis_tlast),
        .o_cls  (cls_in)
    );

    // queue
    blcs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (cls_in),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_empty (fifo_empty),
        .o_rdata (cls_out)
    );

    // tracker
    blcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (fifo_empty),
        .i_cls   (cls_out),
        .o_pop   (fifo_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
